@@ hw/rtl/rc4_pkg.sv @@
// Types and constants shared by the RC4 stream cipher core.
package rc4_pkg;

    localparam int BYTE_W      = 8;
    localparam int SBOX_DEPTH  = 256;
    localparam int SBOX_ADDR_W = 8;
    localparam int KEY_W       = 64;
    localparam int KEY_LEN_W   = 4;
    localparam int KEY_POS_W   = 3;
    localparam int CFG_INDEX_W = 1;

    // Item operation codes
    typedef enum logic [0:0] {
        OP_KEY  = 1'b0,
        OP_BYTE = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_VALUE  = 1'b0,
        REG_KEY_LENGTH = 1'b1
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KSA_RD,
        ST_KSA_J,
        ST_KSA_WK,
        ST_KSA_WJ,
        ST_RD_J,
        ST_SWAP,
        ST_FIN
    } state_t;

endpackage

@@ hw/rtl/rc4_stream_cipher_core.sv @@
// RC4 stream cipher core: permutation memory, key schedule and byte sequencer.
//
// The permutation lives in one 256 x 8 synchronous memory with one registered
// read port and one write port; every step is a read, modify and write-back
// through that memory. A byte item runs in steps: the accept step reads S[i],
// the next reads S[j], the third writes S[i] and reads the keystream entry,
// and the fourth writes S[j] and loads the result while the next item is
// taken. Back-to-back byte items therefore overlap in that step while the
// result side keeps up. A key-schedule item gives no result and holds the
// core while it loads the 256-entry identity and then runs 256 shuffle steps,
// each a read of S[k], a read of S[j] and writes of both. Bytes sent
// before the first key schedule are taken and dropped. A start-of-line flag
// clears i and j before its byte; the permutation is kept.
module rc4_stream_cipher_core #(
    parameter int KEY_MAX_BYTES = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rc4_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rc4_pkg::KEY_W-1:0]          cfg_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic                               s_first_of_line,
    input  logic [rc4_pkg::BYTE_W-1:0]         s_data_byte,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rc4_pkg::BYTE_W-1:0]         m_out_byte
);

    localparam logic [rc4_pkg::KEY_LEN_W-1:0] KEY_MAX_LEN =
        rc4_pkg::KEY_LEN_W'(KEY_MAX_BYTES);

    // Configuration registers
    logic [rc4_pkg::KEY_W-1:0]       key_value_reg;
    logic [rc4_pkg::KEY_LEN_W-1:0]   key_length_reg;

    // Sequencer and index state
    rc4_pkg::state_t                 state_reg, state_next;
    logic                            keyed_reg, keyed_next;
    logic [rc4_pkg::SBOX_ADDR_W-1:0] k_reg, k_next;
    logic [rc4_pkg::KEY_POS_W-1:0]   pos_reg, pos_next;
    logic [rc4_pkg::SBOX_ADDR_W-1:0] i_reg, i_next;
    logic [rc4_pkg::SBOX_ADDR_W-1:0] j_reg, j_next;

    // Datapath holding registers
    logic [rc4_pkg::BYTE_W-1:0]      si_reg, si_next;
    logic [rc4_pkg::BYTE_W-1:0]      sj_reg, sj_next;
    logic [rc4_pkg::SBOX_ADDR_W-1:0] t_reg, t_next;
    logic [rc4_pkg::BYTE_W-1:0]      data_reg, data_next;
    logic                            fwd_hit_reg, fwd_hit_next;
    logic [rc4_pkg::BYTE_W-1:0]      fwd_val_reg, fwd_val_next;

    // Result register
    logic                            out_valid_reg, out_valid_next;
    logic [rc4_pkg::BYTE_W-1:0]      out_byte_reg, out_byte_next;

    // Permutation memory
    logic [rc4_pkg::BYTE_W-1:0]      sbox_mem [rc4_pkg::SBOX_DEPTH];
    logic [rc4_pkg::BYTE_W-1:0]      sbox_rdata_reg;
    logic [rc4_pkg::SBOX_ADDR_W-1:0] rd_addr;
    logic                            wr_en;
    logic [rc4_pkg::SBOX_ADDR_W-1:0] wr_addr;
    logic [rc4_pkg::BYTE_W-1:0]      wr_data;

    // Combinational helpers
    logic                            out_free;
    logic                            ready_c;
    logic                            in_acc;
    logic [rc4_pkg::KEY_LEN_W-1:0]   key_len_eff;
    logic [rc4_pkg::BYTE_W-1:0]      key_byte;
    logic [rc4_pkg::SBOX_ADDR_W-1:0] i_start;
    logic [rc4_pkg::SBOX_ADDR_W-1:0] ksa_j_new;
    logic [rc4_pkg::BYTE_W-1:0]      si_eff;
    logic [rc4_pkg::BYTE_W-1:0]      ks_byte;

    assign cfg_ready  = 1'b1;
    assign s_ready    = ready_c;
    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign in_acc   = s_valid && ready_c;

    // Clamp key length to the supported range
    always_comb begin
        if (key_length_reg == '0) begin
            key_len_eff = rc4_pkg::KEY_LEN_W'(1);
        end else if (key_length_reg > KEY_MAX_LEN) begin
            key_len_eff = KEY_MAX_LEN;
        end else begin
            key_len_eff = key_length_reg;
        end
    end

    assign key_byte  = key_value_reg[{pos_reg, 3'b000} +: rc4_pkg::BYTE_W];
    assign i_start   = (s_first_of_line ? '0 : i_reg) + rc4_pkg::SBOX_ADDR_W'(1);
    assign ksa_j_new = j_reg + sbox_rdata_reg + key_byte;
    assign si_eff    = fwd_hit_reg ? fwd_val_reg : sbox_rdata_reg;

    // Keystream entry: S[j] is written last, so a hit on j wins
    always_comb begin
        priority if (t_reg == j_reg) begin
            ks_byte = si_reg;
        end else if (t_reg == i_reg) begin
            ks_byte = sj_reg;
        end else begin
            ks_byte = sbox_rdata_reg;
        end
    end

    // Next state, memory control and handshake
    always_comb begin
        state_next     = state_reg;
        keyed_next     = keyed_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        data_next      = data_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_val_next   = fwd_val_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        ready_c        = 1'b0;
        rd_addr        = k_reg;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = k_reg;

        unique case (state_reg)
            rc4_pkg::ST_IDLE: begin
                ready_c = out_free;
            end
            rc4_pkg::ST_FILL: begin
                // load the identity permutation
                wr_en = 1'b1;
                if (k_reg == '1) begin
                    k_next     = '0;
                    pos_next   = '0;
                    j_next     = '0;
                    state_next = rc4_pkg::ST_KSA_RD;
                end else begin
                    k_next = k_reg + rc4_pkg::SBOX_ADDR_W'(1);
                end
            end
            rc4_pkg::ST_KSA_RD: begin
                rd_addr    = k_reg;
                state_next = rc4_pkg::ST_KSA_J;
            end
            rc4_pkg::ST_KSA_J: begin
                // advance j with the key byte and fetch S[j]
                si_next = sbox_rdata_reg;
                j_next  = ksa_j_new;
                rd_addr = ksa_j_new;
                if ({1'b0, pos_reg} == rc4_pkg::KEY_LEN_W'(key_len_eff - 4'd1)) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_reg + rc4_pkg::KEY_POS_W'(1);
                end
                state_next = rc4_pkg::ST_KSA_WK;
            end
            rc4_pkg::ST_KSA_WK: begin
                wr_en      = 1'b1;
                wr_addr    = k_reg;
                wr_data    = sbox_rdata_reg;
                state_next = rc4_pkg::ST_KSA_WJ;
            end
            rc4_pkg::ST_KSA_WJ: begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = si_reg;
                if (k_reg == '1) begin
                    k_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                    state_next = rc4_pkg::ST_IDLE;
                end else begin
                    k_next     = k_reg + rc4_pkg::SBOX_ADDR_W'(1);
                    state_next = rc4_pkg::ST_KSA_RD;
                end
            end
            rc4_pkg::ST_RD_J: begin
                // advance j and fetch S[j]
                si_next    = si_eff;
                j_next     = j_reg + si_eff;
                rd_addr    = j_reg + si_eff;
                state_next = rc4_pkg::ST_SWAP;
            end
            rc4_pkg::ST_SWAP: begin
                // write S[i] and fetch the keystream entry
                sj_next    = sbox_rdata_reg;
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = sbox_rdata_reg;
                t_next     = si_reg + sbox_rdata_reg;
                rd_addr    = si_reg + sbox_rdata_reg;
                state_next = rc4_pkg::ST_FIN;
            end
            rc4_pkg::ST_FIN: begin
                // write S[j], deliver the result when the slot is free
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = si_reg;
                rd_addr = t_reg;
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks_byte;
                    ready_c        = 1'b1;
                    state_next     = rc4_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase

        // Take a new item
        if (s_valid && ready_c) begin
            fwd_hit_next = (state_reg == rc4_pkg::ST_FIN) && (i_start == j_reg);
            fwd_val_next = si_reg;
            if (s_opcode == rc4_pkg::OP_KEY) begin
                k_next     = '0;
                state_next = rc4_pkg::ST_FILL;
            end else if (keyed_reg) begin
                i_next     = i_start;
                j_next     = s_first_of_line ? '0 : j_reg;
                data_next  = s_data_byte;
                rd_addr    = i_start;
                state_next = rc4_pkg::ST_RD_J;
            end else begin
                state_next = rc4_pkg::ST_IDLE;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rc4_pkg::ST_IDLE;
            keyed_reg      <= 1'b0;
            k_reg          <= '0;
            pos_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            fwd_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            key_value_reg  <= '0;
            key_length_reg <= rc4_pkg::KEY_LEN_W'(5);
        end else begin
            state_reg     <= state_next;
            keyed_reg     <= keyed_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (rc4_pkg::cfg_reg_t'(cfg_index))
                    rc4_pkg::REG_KEY_VALUE: begin
                        key_value_reg <= cfg_data;
                    end
                    rc4_pkg::REG_KEY_LENGTH: begin
                        key_length_reg <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
                    end
                    default: begin
                        key_value_reg <= key_value_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        data_reg     <= data_next;
        fwd_val_reg  <= fwd_val_next;
        out_byte_reg <= out_byte_next;
    end

    // Permutation memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sbox_mem[wr_addr] <= wr_data;
        end
        sbox_rdata_reg <= sbox_mem[rd_addr];
    end

    // Once keyed, the core stays keyed
    assert property (@(posedge aclk) disable iff (!aresetn)
        keyed_reg |=> keyed_reg)
        else $error("keyed flag dropped");

    // A completed key schedule leaves both indices at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rc4_pkg::ST_KSA_WJ && k_reg == '1) |=>
            (i_reg == '0 && j_reg == '0 && state_reg == rc4_pkg::ST_IDLE))
        else $error("indices not cleared after key schedule");

    // A keyed byte item starts the byte sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_opcode == rc4_pkg::OP_BYTE && keyed_reg) |=>
            (state_reg == rc4_pkg::ST_RD_J))
        else $error("byte item not started");

    // A result is only loaded from the final byte step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg && !m_ready)) |->
            ($past(state_reg) == rc4_pkg::ST_FIN))
        else $error("result loaded outside final step");

    // No item is taken while a result waits unread
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !s_ready)
        else $error("item taken while output blocked");

endmodule
